// ===== hdl/lems_pkg.sv =====
// Shared types, constants and register codes for the line exact match scanner.
package lems_pkg;

  localparam int DEF_MAX_KEY_BYTES = 32;
  localparam int KEY_STORE_BYTES   = 32;
  localparam int KEY_LEN_W         = 6;
  localparam int KEY_WORD_W        = 64;
  localparam int CFG_IDX_W         = 3;
  localparam int COUNT_W           = 32;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LEN = 3'd0,
    REG_KEY_W0  = 3'd1,
    REG_KEY_W1  = 3'd2,
    REG_KEY_W2  = 3'd3,
    REG_KEY_W3  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic       eof;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic               file_done;
    logic               key_found;
    logic               record_matched;
    logic [COUNT_W-1:0] record_count;
  } res_t;

endpackage

// ===== hdl/lems_cfg_regs.sv =====
// Key length and key byte registers written through the configuration channel.
module lems_cfg_regs
  import lems_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [CFG_IDX_W-1:0]              wr_idx,
  input  logic [KEY_WORD_W-1:0]             wr_data,
  output logic [KEY_LEN_W-1:0]              key_len,
  output logic [KEY_STORE_BYTES*8-1:0]      key_vec
);

  logic [KEY_LEN_W-1:0]  key_len_r;
  logic [KEY_WORD_W-1:0] key_w0_r, key_w1_r, key_w2_r, key_w3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= '0;
      key_w0_r  <= '0;
      key_w1_r  <= '0;
      key_w2_r  <= '0;
      key_w3_r  <= '0;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_idx))
        REG_KEY_LEN: begin
          key_len_r <= wr_data[KEY_LEN_W-1:0];
        end
        REG_KEY_W0: begin
          key_w0_r <= wr_data;
        end
        REG_KEY_W1: begin
          key_w1_r <= wr_data;
        end
        REG_KEY_W2: begin
          key_w2_r <= wr_data;
        end
        REG_KEY_W3: begin
          key_w3_r <= wr_data;
        end
        default: begin
        end
      endcase
    end
  end

  assign key_len = key_len_r;
  assign key_vec = {key_w3_r, key_w2_r, key_w1_r, key_w0_r};

endmodule

// ===== hdl/lems_in_reg.sv =====
// Input register holding one accepted beat until the scan stage takes it.
module lems_in_reg
  import lems_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  s_valid,
  output logic  s_ready,
  input  item_t s_item,
  input  logic  adv,
  output logic  item_vld,
  output item_t item
);

  logic  vld_r, vld_nxt;
  item_t item_r;
  logic  take;

  assign s_ready = !vld_r || adv;
  assign take    = s_valid && s_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= s_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

// ===== hdl/lems_core.sv =====
// Line state, per-byte key compare, record count and result register.
module lems_core
  import lems_pkg::*;
#(
  parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         item_vld,
  input  item_t                        item,
  input  logic [KEY_LEN_W-1:0]         key_len,
  input  logic [KEY_STORE_BYTES*8-1:0] key_vec,
  input  logic                         res_ready,
  output logic                         adv,
  output logic                         res_vld,
  output res_t                         res
);

  localparam int POS_W = $clog2(MAX_KEY_BYTES + 2);
  localparam int CW    = (POS_W > KEY_LEN_W) ? POS_W : KEY_LEN_W;
  localparam int KIDX_W = $clog2(KEY_STORE_BYTES);

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               mism_r, mism_nxt;
  logic               pend_r, pend_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic               latch_r, latch_nxt;
  logic               res_vld_r, res_vld_nxt;
  res_t               res_r, res_calc;
  logic               emit;

  logic [CW-1:0]      pos_w, len_w, eff_len;
  logic [KIDX_W-1:0]  kidx;
  logic [7:0]         key_byte;
  logic               hit;
  logic [COUNT_W-1:0] cnt_inc;
  logic               fire;

  assign adv  = !res_vld_r || res_ready;
  assign fire = item_vld && adv;

  assign pos_w   = CW'(pos_r);
  assign len_w   = CW'(key_len);
  assign eff_len = (len_w > CW'(MAX_KEY_BYTES)) ? CW'(MAX_KEY_BYTES) : len_w;
  assign kidx    = pos_w[KIDX_W-1:0];
  assign key_byte = (pos_w < CW'(KEY_STORE_BYTES)) ? key_vec[{kidx, 3'b000} +: 8] : 8'h00;
  assign hit     = !mism_r && (pos_w == eff_len);
  assign cnt_inc = (cnt_r == {COUNT_W{1'b1}}) ? cnt_r : cnt_r + COUNT_W'(1);

  always_comb begin
    pos_nxt   = pos_r;
    mism_nxt  = mism_r;
    pend_nxt  = pend_r;
    cnt_nxt   = cnt_r;
    latch_nxt = latch_r;
    emit      = 1'b0;
    res_calc  = '0;
    if (item.eof) begin
      emit = 1'b1;
      res_calc.file_done = 1'b1;
      if (!latch_r && pos_r != '0) begin
        res_calc.record_count   = cnt_inc;
        res_calc.record_matched = hit;
        res_calc.key_found      = hit;
      end else begin
        res_calc.record_count = cnt_r;
        res_calc.key_found    = latch_r;
      end
      pos_nxt   = '0;
      mism_nxt  = 1'b0;
      pend_nxt  = 1'b0;
      cnt_nxt   = '0;
      latch_nxt = 1'b0;
    end else if (!latch_r) begin
      pend_nxt = 1'b0;
      if (pend_r && item.data == CHAR_LF) begin
        // swallow LF of a CR LF pair
      end else if (item.data == CHAR_LF || item.data == CHAR_CR) begin
        emit      = 1'b1;
        cnt_nxt   = cnt_inc;
        latch_nxt = hit;
        pos_nxt   = '0;
        mism_nxt  = 1'b0;
        pend_nxt  = (item.data == CHAR_CR);
        res_calc.record_count   = cnt_inc;
        res_calc.record_matched = hit;
        res_calc.key_found      = hit;
      end else begin
        if (pos_w >= eff_len || key_byte != item.data) begin
          mism_nxt = 1'b1;
        end
        if (pos_w < CW'(MAX_KEY_BYTES + 1)) begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
    end
  end

  always_comb begin
    res_vld_nxt = res_vld_r;
    if (adv) begin
      res_vld_nxt = fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      mism_r    <= 1'b0;
      pend_r    <= 1'b0;
      cnt_r     <= '0;
      latch_r   <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= res_vld_nxt;
      if (fire) begin
        pos_r   <= pos_nxt;
        mism_r  <= mism_nxt;
        pend_r  <= pend_nxt;
        cnt_r   <= cnt_nxt;
        latch_r <= latch_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      res_r <= res_calc;
    end
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;

endmodule

// ===== hdl/line_exact_match_scanner.sv =====
// Top level of the line exact match scanner: record split, key compare, count.
//
//   channel | dir | handshake               | payload
//   in_     | in  | in_tvalid / in_tready   | tdata: data_byte; tuser: command
//   out_    | out | out_tvalid / out_tready | tdata: count, matched, found, done
//   cfg_    | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One input beat per cycle while the output is not stalled; a beat waits in the
// input register; each line end or file end then registers a result for out_.
// Reset clears line state, count and key registers; cfg_ready is always high.
// A stalled output holds the result and the input register, which then drops
// in_tready once it is full.
module line_exact_match_scanner
  import lems_pkg::*;
#(
  parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tuser,   // [0] command
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata,  // [31:0] record_count, [32] record_matched,
                                            // [33] key_found, [34] file_done, [39:35] zero
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [KEY_WORD_W-1:0] cfg_data
);

  logic [KEY_LEN_W-1:0]         key_len;
  logic [KEY_STORE_BYTES*8-1:0] key_vec;
  item_t                        s_item, item;
  logic                         item_vld;
  logic                         adv;
  res_t                         res;

  assign cfg_ready = 1'b1;
  assign s_item    = '{eof: in_tuser, data: in_tdata};

  lems_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .key_len (key_len),
    .key_vec (key_vec)
  );

  lems_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_valid  (in_tvalid),
    .s_ready  (in_tready),
    .s_item   (s_item),
    .adv      (adv),
    .item_vld (item_vld),
    .item     (item)
  );

  lems_core #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (item_vld),
    .item      (item),
    .key_len   (key_len),
    .key_vec   (key_vec),
    .res_ready (out_tready),
    .adv       (adv),
    .res_vld   (out_tvalid),
    .res       (res)
  );

  assign out_tdata = {5'b00000, res.file_done, res.key_found, res.record_matched,
                      res.record_count};

  a_match_sets_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[32]) |-> out_tdata[33])
    else $error("record match without key_found");

  a_match_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[32]) |-> (out_tdata[31:0] != 32'd0))
    else $error("matched record with zero count");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (item_vld && out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while pipeline is stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !item_vld |-> in_tready)
    else $error("input register empty but not ready");

endmodule
